FILE: hw/rtl/cwra_pkg.sv
`default_nettype none
package cwra_pkg;

  // frame size limits
  localparam int unsigned MAX_WIDTH  = 4096;
  localparam int unsigned MAX_HEIGHT = 4096;
  localparam int COL_W = $clog2(MAX_WIDTH);
  localparam int ROW_W = $clog2(MAX_HEIGHT);
  localparam int DIM_W = (COL_W > ROW_W) ? COL_W : ROW_W;

  // configuration port
  localparam int CFG_W = 13;
  localparam int FMT_W = 3;
  localparam int IDX_W = 2;
  localparam logic [IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
  localparam logic [IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;
  localparam logic [IDX_W-1:0] REG_PIXEL_FORMAT = 2'd2;
  localparam logic [CFG_W-1:0] RST_FRAME_WIDTH  = 13'd640;
  localparam logic [CFG_W-1:0] RST_FRAME_HEIGHT = 13'd480;

  // pixel formats
  localparam logic [FMT_W-1:0] FMT_ABGR = 3'd0;
  localparam logic [FMT_W-1:0] FMT_BGRA = 3'd1;
  localparam logic [FMT_W-1:0] FMT_BGR  = 3'd2;
  localparam logic [FMT_W-1:0] FMT_RGBA = 3'd3;
  localparam logic [FMT_W-1:0] FMT_RGB  = 3'd4;
  localparam logic [FMT_W-1:0] RST_PIXEL_FORMAT = FMT_RGB;

  // channels and accumulators
  localparam int NUM_CH  = 3;
  localparam int CH_RED   = 0;
  localparam int CH_GREEN = 1;
  localparam int CH_BLUE  = 2;
  localparam int BYTE_W  = 8;
  localparam int SUM_W   = 32;
  localparam int COUNT_W = 24;
  localparam int STEP_W  = $clog2(SUM_W);

  typedef logic [NUM_CH-1:0][SUM_W-1:0]  sum_vec_t;
  typedef logic [NUM_CH-1:0][BYTE_W-1:0] avg_vec_t;

  // last index and window bounds of one frame dimension
  typedef struct packed {
    logic [DIM_W-1:0] last;
    logic [DIM_W-1:0] lo;
    logic [DIM_W-1:0] hi;
  } dims_t;

  // controller to datapath commands
  typedef struct packed {
    logic div_load;
    logic div_step;
    logic res_load;
  } ctrl_cmd_t;

  function automatic dims_t size_dims(input logic [CFG_W-1:0] raw, input int unsigned maxv);
    int unsigned v;
    dims_t d;
    v = 32'(raw);
    if (v == 0) begin
      v = 1;
    end else if (v > maxv) begin
      v = maxv;
    end
    d.last = DIM_W'(v - 1);
    d.lo   = DIM_W'(v >> 2);
    d.hi   = DIM_W'((v * 3) >> 2);
    return d;
  endfunction

endpackage
`default_nettype wire

FILE: hw/rtl/cwra_accum.sv
`default_nettype none
module cwra_accum
  import cwra_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              cfg_write,
  input  wire logic [IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_W-1:0]  cfg_data,
  input  wire logic              accept,
  input  wire logic              frame_start,
  input  wire logic [BYTE_W-1:0] pixel_byte0,
  input  wire logic [BYTE_W-1:0] pixel_byte1,
  input  wire logic [BYTE_W-1:0] pixel_byte2,
  input  wire logic [BYTE_W-1:0] pixel_byte3,
  output logic                   frame_end,
  output sum_vec_t               sum_next,
  output logic [COUNT_W-1:0]     count_next
);

  dims_t            col_dims;
  dims_t            row_dims;
  logic [FMT_W-1:0] pixel_format;

  logic [COL_W-1:0]   column_position;
  logic [ROW_W-1:0]   row_position;
  sum_vec_t           sums;
  logic [COUNT_W-1:0] window_count;

  logic [COL_W-1:0]   col_cur;
  logic [ROW_W-1:0]   row_cur;
  sum_vec_t           sum_base;
  logic [COUNT_W-1:0] count_base;
  logic               in_window;
  logic               row_end;
  avg_vec_t           ch_val;

  always_comb begin
    col_cur    = frame_start ? '0 : column_position;
    row_cur    = frame_start ? '0 : row_position;
    sum_base   = frame_start ? '0 : sums;
    count_base = frame_start ? '0 : window_count;

    in_window = (DIM_W'(col_cur) >= col_dims.lo) && (DIM_W'(col_cur) <= col_dims.hi) &&
                (DIM_W'(row_cur) >= row_dims.lo) && (DIM_W'(row_cur) <= row_dims.hi);

    ch_val = '0;
    case (pixel_format)
      FMT_ABGR: begin
        ch_val[CH_RED]   = pixel_byte3;
        ch_val[CH_GREEN] = pixel_byte2;
        ch_val[CH_BLUE]  = pixel_byte1;
      end
      FMT_BGRA, FMT_BGR: begin
        ch_val[CH_RED]   = pixel_byte2;
        ch_val[CH_GREEN] = pixel_byte1;
        ch_val[CH_BLUE]  = pixel_byte0;
      end
      FMT_RGBA, FMT_RGB: begin
        ch_val[CH_RED]   = pixel_byte0;
        ch_val[CH_GREEN] = pixel_byte1;
        ch_val[CH_BLUE]  = pixel_byte2;
      end
      default: ch_val = '0;
    endcase

    for (int i = 0; i < NUM_CH; i++) begin
      sum_next[i] = sum_base[i] + (in_window ? SUM_W'(ch_val[i]) : '0);
    end
    count_next = count_base + COUNT_W'(in_window);

    row_end   = DIM_W'(col_cur) >= col_dims.last;
    frame_end = row_end && (DIM_W'(row_cur) >= row_dims.last);
  end

  // sizes are stored already clamped, with their window bounds
  always_ff @(posedge clk) begin
    if (rst) begin
      col_dims     <= size_dims(RST_FRAME_WIDTH, MAX_WIDTH);
      row_dims     <= size_dims(RST_FRAME_HEIGHT, MAX_HEIGHT);
      pixel_format <= RST_PIXEL_FORMAT;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_FRAME_WIDTH:  col_dims     <= size_dims(cfg_data, MAX_WIDTH);
        REG_FRAME_HEIGHT: row_dims     <= size_dims(cfg_data, MAX_HEIGHT);
        REG_PIXEL_FORMAT: pixel_format <= cfg_data[FMT_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_position <= '0;
      row_position    <= '0;
      sums            <= '0;
      window_count    <= '0;
    end else if (accept) begin
      if (frame_end) begin
        column_position <= '0;
        row_position    <= '0;
        sums            <= '0;
        window_count    <= '0;
      end else begin
        sums         <= sum_next;
        window_count <= count_next;
        if (row_end) begin
          column_position <= '0;
          row_position    <= row_cur + 1'b1;
        end else begin
          column_position <= col_cur + 1'b1;
          row_position    <= row_cur;
        end
      end
    end
  end

endmodule
`default_nettype wire

FILE: hw/rtl/cwra_div.sv
`default_nettype none
module cwra_div
  import cwra_pkg::*;
(
  input  wire logic               clk,
  input  wire ctrl_cmd_t          cmd,
  input  wire sum_vec_t           sums,
  input  wire logic [COUNT_W-1:0] count,
  output avg_vec_t                average
);

  // one restoring divider lane per channel, one quotient bit per step
  sum_vec_t           dividend;
  logic [COUNT_W-1:0] divisor;
  logic               div_zero;
  logic [NUM_CH-1:0][COUNT_W-1:0] rem;
  avg_vec_t           quot;

  logic [NUM_CH-1:0][COUNT_W:0]   rem_shift;
  logic [NUM_CH-1:0]              fits;

  always_comb begin
    for (int i = 0; i < NUM_CH; i++) begin
      rem_shift[i] = {rem[i], dividend[i][SUM_W-1]};
      fits[i]      = rem_shift[i] >= {1'b0, divisor};
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.div_load) begin
      dividend <= sums;
      divisor  <= count;
      div_zero <= (count == '0);
      rem      <= '0;
      quot     <= '0;
    end else if (cmd.div_step) begin
      for (int i = 0; i < NUM_CH; i++) begin
        dividend[i] <= {dividend[i][SUM_W-2:0], 1'b0};
        rem[i]      <= fits[i] ? COUNT_W'(rem_shift[i] - {1'b0, divisor})
                               : rem_shift[i][COUNT_W-1:0];
        quot[i]     <= {quot[i][BYTE_W-2:0], fits[i]};
      end
    end
  end

  // result register, held until the item is taken
  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      average <= div_zero ? '0 : quot;
    end
  end

endmodule
`default_nettype wire

FILE: hw/rtl/cwra_ctrl.sv
`default_nettype none
module cwra_ctrl
  import cwra_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid,
  input  wire logic out_ready,
  input  wire logic frame_end,
  output logic      in_ready,
  output logic      out_valid,
  output ctrl_cmd_t cmd
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_DIV  = 3'b010,
    S_DONE = 3'b100
  } state_t;

  localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(SUM_W - 1);

  state_t            state, state_next;
  logic [STEP_W-1:0] step_cnt, step_cnt_next;
  logic              out_full, out_full_next;

  // a frame end needs the divider, other pixels always pass
  assign in_ready  = (state == S_IDLE) || !frame_end;
  assign out_valid = out_full;

  always_comb begin
    state_next    = state;
    step_cnt_next = step_cnt;
    out_full_next = out_full;
    cmd           = '0;
    if (out_full && out_ready) begin
      out_full_next = 1'b0;
    end
    case (state)
      S_IDLE: begin
        if (in_valid && frame_end) begin
          cmd.div_load  = 1'b1;
          step_cnt_next = '0;
          state_next    = S_DIV;
        end
      end
      S_DIV: begin
        cmd.div_step  = 1'b1;
        step_cnt_next = step_cnt + 1'b1;
        if (step_cnt == STEP_LAST) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_full || out_ready) begin
          cmd.res_load  = 1'b1;
          out_full_next = 1'b1;
          state_next    = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      step_cnt <= '0;
      out_full <= 1'b0;
    end else begin
      state    <= state_next;
      step_cnt <= step_cnt_next;
      out_full <= out_full_next;
    end
  end

  a_load_idle : assert property (@(posedge clk) disable iff (rst)
    cmd.div_load |-> (state == S_IDLE) && in_valid && in_ready)
    else $error("divider loaded outside idle");

  a_load_start : assert property (@(posedge clk) disable iff (rst)
    cmd.div_load |=> (state == S_DIV) && (step_cnt == '0))
    else $error("division did not start at step zero");

  a_no_overwrite : assert property (@(posedge clk) disable iff (rst)
    cmd.res_load |-> !out_full || out_ready)
    else $error("result overwritten before taken");

  a_stall_busy : assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> (state != S_IDLE) && frame_end)
    else $error("input stalled while divider free");

endmodule
`default_nettype wire

FILE: hw/rtl/center_window_rgb_average.sv
// channel   signals                                           direction
// -------   -----------------------------------------------   ---------
// pixel     in_valid in_ready frame_start pixel_byte0..3      in
// average   out_valid out_ready average_red/green/blue         out
// config    cfg_write cfg_index cfg_data                       in
//
// one pixel item is taken per cycle unless a frame end is held off; sums update in the cycle of acceptance
// the last pixel of a frame starts a 32-step restoring division (three lanes),
// so its result reaches the output register once the division finishes, or later if output stalls
// a frame end arriving while the previous division is still busy is held off;
// frames of 34 pixels or more never stall the input while the output keeps up
// synchronous reset restores the default 640x480 rgb setup and clears position, sums and control state
`default_nettype none
module center_window_rgb_average
  import cwra_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  // pixel items
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic               frame_start,
  input  wire logic [BYTE_W-1:0]  pixel_byte0,
  input  wire logic [BYTE_W-1:0]  pixel_byte1,
  input  wire logic [BYTE_W-1:0]  pixel_byte2,
  input  wire logic [BYTE_W-1:0]  pixel_byte3,
  // average items
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [BYTE_W-1:0]       average_red,
  output logic [BYTE_W-1:0]       average_green,
  output logic [BYTE_W-1:0]       average_blue,
  // register writes
  input  wire logic               cfg_write,
  input  wire logic [IDX_W-1:0]   cfg_index,
  input  wire logic [CFG_W-1:0]   cfg_data
);

  ctrl_cmd_t          cmd;
  logic               frame_end;
  logic               accept;
  sum_vec_t           sum_next;
  logic [COUNT_W-1:0] count_next;
  avg_vec_t           average;

  assign accept = in_valid && in_ready;

  // position tracking, window test and per-channel sums
  cwra_accum u_accum (
    .clk         (clk),
    .rst         (rst),
    .cfg_write   (cfg_write),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .accept      (accept),
    .frame_start (frame_start),
    .pixel_byte0 (pixel_byte0),
    .pixel_byte1 (pixel_byte1),
    .pixel_byte2 (pixel_byte2),
    .pixel_byte3 (pixel_byte3),
    .frame_end   (frame_end),
    .sum_next    (sum_next),
    .count_next  (count_next)
  );

  // sequences division and output handshake
  cwra_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .out_ready (out_ready),
    .frame_end (frame_end),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .cmd       (cmd)
  );

  // snapshot of the frame totals is divided while the next frame accumulates
  cwra_div u_div (
    .clk     (clk),
    .cmd     (cmd),
    .sums    (sum_next),
    .count   (count_next),
    .average (average)
  );

  assign average_red   = average[CH_RED];
  assign average_green = average[CH_GREEN];
  assign average_blue  = average[CH_BLUE];

endmodule
`default_nettype wire
